>>> rtl/sorted_insert_table_unit_assert.svh
// Assertion macros used by the top level of the sorted insert table RTL.
`ifndef SORTED_INSERT_TABLE_UNIT_ASSERT_SVH
`define SORTED_INSERT_TABLE_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SIT_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that, when it holds, forces another one in the next cycle.
`define SIT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sit_pkg.sv
// Package with the types and constants of the sorted insert table.
`default_nettype none

package sit_pkg;

   // Default table size and entry width.
   localparam int SIT_DEPTH       = 16;
   localparam int SIT_VALUE_WIDTH = 32;

   // Fixed field widths of the request and response transfers.
   localparam int SIT_FIELD_WIDTH = 32;
   localparam int SIT_INDEX_WIDTH = 4;
   localparam int SIT_POS_WIDTH   = 5;

   // Operation codes.
   typedef enum logic [0:0] {
      SIT_OP_INSERT = 1'b0,
      SIT_OP_READ   = 1'b1
   } sit_op_type;

   // One request transfer.
   typedef struct packed {
      sit_op_type                         operation;
      logic signed [SIT_FIELD_WIDTH-1:0]  value;
      logic        [SIT_INDEX_WIDTH-1:0]  index;
   } sit_req_type;

   // One response transfer.
   typedef struct packed {
      logic signed [SIT_FIELD_WIDTH-1:0]  read_value;
      logic                               read_valid;
      logic        [SIT_POS_WIDTH-1:0]    insert_position;
      logic        [SIT_POS_WIDTH-1:0]    entry_count;
      logic                               dropped;
   } sit_rsp_type;

endpackage

`default_nettype wire

>>> rtl/sorted_insert_table_unit.sv
// Top level of the sorted insert table: a chain of entry cells with count and response logic.
// The response strobe is registered and comes in the cycle after the request transfer.
// Throughput: one request per cycle outside reset; every cell compares and shifts in the same cycle.
// busy is high only while reset is asserted; the receiver cannot stall responses.
// Reset clears the entry count and the response strobe; entry contents stay undefined.
`default_nettype none

module sorted_insert_table_unit
   import sit_pkg::*;
#(
   parameter int DEPTH       = SIT_DEPTH,
   parameter int VALUE_WIDTH = SIT_VALUE_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire sit_req_type req_data,
   output      logic        rsp_strobe,
   output      sit_rsp_type rsp_data
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int XW   = (CW > SIT_INDEX_WIDTH) ? CW : SIT_INDEX_WIDTH;
   localparam int WIDE = (VALUE_WIDTH > SIT_FIELD_WIDTH) ? VALUE_WIDTH : SIT_FIELD_WIDTH;

   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic                   strobe_ff;
   sit_rsp_type            rsp_ff;
   sit_rsp_type            rsp_in;

   logic                   accept;
   logic                   full;
   logic                   ins_en;
   logic [WIDE-1:0]        in_wide;
   logic [VALUE_WIDTH-1:0] ins_value;

   logic [VALUE_WIDTH-1:0] cell_entry [DEPTH];
   logic [DEPTH-1:0]       cell_shift;
   logic [DEPTH-1:0]       cell_first;
   logic [CW-1:0]          ins_pos;

   logic [AW-1:0]          rd_addr;
   logic                   rd_valid;
   logic [WIDE-1:0]        rd_wide;

   // Request transfer and the insert decision.
   assign busy     = reset;
   assign accept   = start && !busy;
   assign full     = count_ff == CW'(DEPTH);
   assign ins_en   = accept && (req_data.operation == SIT_OP_INSERT) && !full;

   // Bring the value field to the entry width.
   assign in_wide   = WIDE'($unsigned(req_data.value));
   assign ins_value = in_wide[VALUE_WIDTH-1:0];

   // The chain of cells; each sees its left neighbor's entry and shift flag.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_entry;
      logic                   left_shift;

      if (i == 0) begin : g_head
         assign left_entry = ins_value;
         assign left_shift = 1'b0;
      end else begin : g_link
         assign left_entry = cell_entry[i-1];
         assign left_shift = cell_shift[i-1];
      end

      sit_cell #(
         .INDEX       (i),
         .DEPTH       (DEPTH),
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ins_en     (ins_en),
         .ins_value  (ins_value),
         .count      (count_ff),
         .left_entry (left_entry),
         .left_shift (left_shift),
         .entry      (cell_entry[i]),
         .shift      (cell_shift[i]),
         .first      (cell_first[i])
      );
   end

   // The insert lands at the first cell that shifts, or at the tail when none does.
   always_comb begin
      ins_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_first[i]) begin
            ins_pos = ins_pos | CW'(i);
         end
      end
      if (cell_first == '0) begin
         ins_pos = count_ff;
      end
   end

   // Read path: a read is valid only below the count.
   assign rd_addr  = AW'(req_data.index);
   assign rd_valid = XW'(req_data.index) < XW'(count_ff);
   assign rd_wide  = WIDE'($signed(cell_entry[rd_addr]));

   // Next count and the response fields.
   always_comb begin
      count_in = count_ff;
      if (ins_en) begin
         count_in = count_ff + CW'(1);
      end

      rsp_in                 = '0;
      rsp_in.entry_count     = SIT_POS_WIDTH'(count_in);
      if (req_data.operation == SIT_OP_READ) begin
         if (rd_valid) begin
            rsp_in.read_valid = 1'b1;
            rsp_in.read_value = rd_wide[SIT_FIELD_WIDTH-1:0];
         end
      end else if (full) begin
         rsp_in.dropped = 1'b1;
      end else begin
         rsp_in.insert_position = SIT_POS_WIDTH'(ins_pos);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

`include "sorted_insert_table_unit_assert.svh"

   // The count never passes the table size.
   `SIT_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "count exceeds depth")
   // The table stays sorted, so at most one cell starts the shifted run.
   `SIT_ASSERT_ALWAYS(a_one_boundary, clock, reset, $onehot0(cell_first), "table out of order")
   // Every request transfer yields exactly one response in the next cycle.
   `SIT_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_strobe, "missing response")
   `SIT_ASSERT_NEXT(a_no_extra_rsp, clock, reset, !accept, !rsp_strobe, "spurious response")

endmodule

`default_nettype wire

>>> rtl/sit_cell.sv
// One cell of the sorted table: holds a single entry and shifts it to the right neighbor.
`default_nettype none

module sit_cell
   import sit_pkg::*;
#(
   parameter int INDEX       = 0,
   parameter int DEPTH       = SIT_DEPTH,
   parameter int VALUE_WIDTH = SIT_VALUE_WIDTH,
   localparam int CW         = $clog2(DEPTH + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   ins_en,
   input  wire logic [VALUE_WIDTH-1:0] ins_value,
   input  wire logic [CW-1:0]          count,
   input  wire logic [VALUE_WIDTH-1:0] left_entry,
   input  wire logic                   left_shift,
   output      logic [VALUE_WIDTH-1:0] entry,
   output      logic                   shift,
   output      logic                   first
);

   logic [VALUE_WIDTH-1:0] entry_ff;
   logic [VALUE_WIDTH-1:0] entry_in;
   logic                   occupied;
   logic                   tail;

   // This cell holds a live entry below the count, or is the next free slot.
   assign occupied = CW'(INDEX) < count;
   assign tail     = CW'(INDEX) == count;

   // A live entry greater than the new value moves up one place.
   assign shift = occupied && ($signed(entry_ff) > $signed(ins_value));
   assign first = shift && !left_shift;

   // Take the left neighbor's entry when it moves, else the new value lands here.
   always_comb begin
      entry_in = entry_ff;
      if (ins_en && (shift || tail)) begin
         entry_in = left_shift ? left_entry : ins_value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire
